### rtl/core/qrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package qrm_pkg;

    localparam int NUM_ENTRIES = 9;
    localparam int QBITS       = 16;
    localparam int NBITS       = 33;
    localparam int NUMBITS     = 35;
    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    typedef struct packed {
        logic             neg;
        logic [NBITS-1:0] rem;
        logic [QBITS-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic                         valid;
        logic                         zero;
        logic [NBITS-1:0]             len2;
        lane_t [NUM_ENTRIES-1:0]      lane;
    } div_t;

endpackage
`default_nettype wire

### rtl/core/qrm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module qrm_front
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic         in_valid,
    input  wire logic [63:0]  in_data,
    output qrm_pkg::div_t     out
);

    localparam int NUMBITS = qrm_pkg::NUMBITS;

    logic signed [15:0] x, y, z, w;
    logic signed [31:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic               va_reg, vb_reg, vc_reg;
    logic [qrm_pkg::NBITS-1:0] n_reg;
    logic signed [qrm_pkg::NUMBITS-1:0] num_reg [qrm_pkg::NUM_ENTRIES];
    logic signed [qrm_pkg::NUMBITS-1:0] num_next [qrm_pkg::NUM_ENTRIES];
    qrm_pkg::div_t c_reg, c_next;

    assign x = $signed(in_data[15:0]);
    assign y = $signed(in_data[31:16]);
    assign z = $signed(in_data[47:32]);
    assign w = $signed(in_data[63:48]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_comb
    begin
        num_next[0] = NUMBITS'(ww_reg) + NUMBITS'(xx_reg) - NUMBITS'(yy_reg) - NUMBITS'(zz_reg);
        num_next[4] = NUMBITS'(ww_reg) + NUMBITS'(yy_reg) - NUMBITS'(xx_reg) - NUMBITS'(zz_reg);
        num_next[8] = NUMBITS'(ww_reg) + NUMBITS'(zz_reg) - NUMBITS'(xx_reg) - NUMBITS'(yy_reg);
        num_next[1] = (NUMBITS'(xy_reg) + NUMBITS'(wz_reg)) <<< 1;
        num_next[2] = (NUMBITS'(xz_reg) - NUMBITS'(wy_reg)) <<< 1;
        num_next[3] = (NUMBITS'(xy_reg) - NUMBITS'(wz_reg)) <<< 1;
        num_next[5] = (NUMBITS'(yz_reg) + NUMBITS'(wx_reg)) <<< 1;
        num_next[6] = (NUMBITS'(xz_reg) + NUMBITS'(wy_reg)) <<< 1;
        num_next[7] = (NUMBITS'(yz_reg) - NUMBITS'(wx_reg)) <<< 1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= x * x;
            yy_reg <= y * y;
            zz_reg <= z * z;
            ww_reg <= w * w;
            xy_reg <= x * y;
            xz_reg <= x * z;
            yz_reg <= y * z;
            wx_reg <= w * x;
            wy_reg <= w * y;
            wz_reg <= w * z;
            n_reg  <= qrm_pkg::NBITS'($unsigned(xx_reg)) + qrm_pkg::NBITS'($unsigned(yy_reg))
                    + qrm_pkg::NBITS'($unsigned(zz_reg)) + qrm_pkg::NBITS'($unsigned(ww_reg));
            for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
            begin
                num_reg[i] <= num_next[i];
            end
            c_reg <= c_next;
        end
    end

    always_comb
    begin
        logic [NUMBITS-1:0] mag;
        c_next       = '0;
        c_next.valid = vb_reg;
        c_next.zero  = (n_reg == '0);
        c_next.len2  = n_reg;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            mag = num_reg[i][NUMBITS-1] ? NUMBITS'(-num_reg[i]) : NUMBITS'(num_reg[i]);
            c_next.lane[i].neg = num_reg[i][NUMBITS-1];
            c_next.lane[i].rem = mag[qrm_pkg::NBITS-1:0];
            c_next.lane[i].quo = '0;
        end
    end

    always_comb
    begin
        out       = c_reg;
        out.valid = vc_reg;
    end

endmodule
`default_nettype wire

### rtl/core/qrm_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
module qrm_div_step
#(
    parameter bit FIRST = 1'b0
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  qrm_pkg::div_t in,
    output qrm_pkg::div_t out
);

    qrm_pkg::div_t d_reg, d_next;
    logic          v_reg;

    always_comb
    begin
        logic [qrm_pkg::NBITS:0] t;
        logic                    ge;
        d_next = in;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            t  = FIRST ? {1'b0, in.lane[i].rem} : {in.lane[i].rem, 1'b0};
            ge = (t >= {1'b0, in.len2});
            d_next.lane[i].rem = ge ? qrm_pkg::NBITS'(t - {1'b0, in.len2})
                                    : t[qrm_pkg::NBITS-1:0];
            d_next.lane[i].quo = {in.lane[i].quo[qrm_pkg::QBITS-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    always_comb
    begin
        out       = d_reg;
        out.valid = v_reg;
    end

endmodule
`default_nettype wire

### rtl/core/qrm_round.sv
`timescale 1ns / 1ps
`default_nettype none
module qrm_round
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  qrm_pkg::div_t      in,
    output logic               out_valid,
    output logic [143:0]       out_data,
    output logic               out_zero
);

    logic         v_reg;
    logic [143:0] data_reg, data_next;
    logic         zero_reg;

    always_comb
    begin
        logic [16:0]        r;
        logic signed [15:0] e;
        for (int i = 0; i < qrm_pkg::NUM_ENTRIES; i++)
        begin
            r = (17'(in.lane[i].quo) + 17'd1) >> 1;
            if (r > 17'(qrm_pkg::ONE_Q14))
            begin
                r = 17'(qrm_pkg::ONE_Q14);
            end
            e = in.lane[i].neg ? -$signed(r[15:0]) : $signed(r[15:0]);
            if (in.zero)
            begin
                e = (i % 4 == 0) ? qrm_pkg::ONE_Q14 : '0;
            end
            data_next[i*16 +: 16] = e;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
            zero_reg <= in.zero;
        end
    end

    assign out_valid = v_reg;
    assign out_data  = data_reg;
    assign out_zero  = zero_reg;

endmodule
`default_nettype wire

### rtl/core/quaternion_to_rotation_matrix_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel        Signals                         Item
// s_axis         tvalid tready tdata[63:0]       quaternion qx, qy, qz, qw (Q3.12)
// m_axis         tvalid tready tdata[143:0] tuser rotation matrix m00..m22 (Q1.14), zero_length
//
// One item per cycle while the output is not stalled; 3 front stages (multiply, sum,
// magnitude), 16 restoring divide stages at one quotient bit each, 1 round/saturate stage.
// Reset clears all stage valid bits; payload registers are not reset.
// A stalled output holds the whole pipeline; s_axis_tready follows that enable.
module quaternion_to_rotation_matrix_top
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // qx, qy, qz, qw
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,   // m00, m01, m02, m10, m11, m12, m20, m21, m22
    output logic              m_axis_tuser    // zero_length
);

    logic          en;
    qrm_pkg::div_t stage [qrm_pkg::QBITS+1];

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    qrm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_axis_tvalid),
        .in_data  (s_axis_tdata),
        .out      (stage[0])
    );

    for (genvar g = 0; g < qrm_pkg::QBITS; g++)
    begin : g_div
        qrm_div_step #(.FIRST(g == 0)) u_step
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .in    (stage[g]),
            .out   (stage[g+1])
        );
    end

    qrm_round u_round
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in        (stage[qrm_pkg::QBITS]),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_zero  (m_axis_tuser)
    );

endmodule
`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic signed [15:0] m [9];
        logic               zero_length;
    } rot_matrix_t;

    class rotation_scoreboard;
        rot_matrix_t pending[$];
        int          errors;

        function logic signed [15:0] round_q14(longint num, longint den);
            longint mag;
            longint q;
            mag = (num < 0) ? -num : num;
            q = (mag * 2 * 16384 + den) / (2 * den);
            if (q > 16384)
                q = 16384;
            return (num < 0) ? 16'(-q) : 16'(q);
        endfunction

        function void note_quaternion(logic signed [15:0] qx, logic signed [15:0] qy,
                                      logic signed [15:0] qz, logic signed [15:0] qw);
            rot_matrix_t r;
            longint x, y, z, w, xx, yy, zz, ww, n;
            x = qx; y = qy; z = qz; w = qw;
            xx = x * x; yy = y * y; zz = z * z; ww = w * w;
            n = xx + yy + zz + ww;
            if (n == 0)
            begin
                foreach (r.m[k])
                    r.m[k] = (k % 4 == 0) ? 16'sd16384 : 16'sd0;
                r.zero_length = 1'b1;
            end
            else
            begin
                r.m[0] = round_q14(ww + xx - yy - zz, n);
                r.m[1] = round_q14(2 * (x * y + w * z), n);
                r.m[2] = round_q14(2 * (x * z - w * y), n);
                r.m[3] = round_q14(2 * (x * y - w * z), n);
                r.m[4] = round_q14(ww + yy - xx - zz, n);
                r.m[5] = round_q14(2 * (y * z + w * x), n);
                r.m[6] = round_q14(2 * (x * z + w * y), n);
                r.m[7] = round_q14(2 * (y * z - w * x), n);
                r.m[8] = round_q14(ww + zz - xx - yy, n);
                r.zero_length = 1'b0;
            end
            pending.push_back(r);
        endfunction

        function void check_matrix(logic [143:0] data, logic zl);
            rot_matrix_t e;
            bit bad;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected matrix %h zero_length %b", data, zl);
                return;
            end
            e = pending.pop_front();
            bad = (zl !== e.zero_length);
            foreach (e.m[k])
                if (data[16*k +: 16] !== e.m[k])
                    bad = 1;
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("matrix mismatch");
                    foreach (e.m[k])
                        $display("  m%0d%0d expected %0d actual %0d", k / 3, k % 3,
                                 e.m[k], $signed(data[16*k +: 16]));
                    $display("  zero_length expected %b actual %b", e.zero_length, zl);
                end
            end
        endfunction
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [143:0] m_axis_tdata;
    logic         m_axis_tuser;

    rotation_scoreboard rotations = new();
    bit  sending_done = 0;
    bit  long_hold = 0;
    int  idle_cycles = 0;

    quaternion_to_rotation_matrix_top dut (.*);

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            rotations.note_quaternion(s_axis_tdata[15:0], s_axis_tdata[31:16],
                                      s_axis_tdata[47:32], s_axis_tdata[63:48]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            rotations.check_matrix(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // stall pattern: long hold once, then randomly chosen phases
    initial
    begin
        int phase;
        @(posedge rst_n);
        repeat (10) @(posedge clk);
        long_hold = 1;
        repeat (200) @(posedge clk);
        long_hold = 0;
        forever
        begin
            phase = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60))
            begin
                @(posedge clk);
                case (phase)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
        if (long_hold)
            m_axis_tready <= 1'b0;

    task automatic send_quaternion(logic [15:0] qx, logic [15:0] qy,
                                   logic [15:0] qz, logic [15:0] qw);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {qw, qz, qy, qx};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic pause_sender();
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_component();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] corner [6];
        int burst;
        int wait_cycles;
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_quaternion(0, 0, 0, 0);
        send_quaternion(16'h1000, 0, 0, 0);
        send_quaternion(0, 16'h1000, 0, 0);
        send_quaternion(0, 0, 16'h1000, 0);
        send_quaternion(0, 0, 0, 16'h1000);
        send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quaternion(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_quaternion(1, 0, 0, 0);
        send_quaternion(16'hFFFF, 0, 0, 0);
        send_quaternion(1, 1, 0, 0);
        send_quaternion(1, 1, 1, 1);
        send_quaternion(16'hFFFF, 1, 16'hFFFF, 1);
        send_quaternion(1, 2, 0, 0);
        send_quaternion(1, 0, 0, 2);
        pause_sender();
        for (int i = 0; i < 6; i++)
            send_quaternion(corner[i], corner[(i + 1) % 6], corner[(i + 3) % 6],
                            corner[(i + 5) % 6]);
        for (int i = 0; i < 900; )
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++, i++)
                send_quaternion(pick_component(), pick_component(), pick_component(),
                                pick_component());
            pause_sender();
        end
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (rotations.pending.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (rotations.errors == 0 && rotations.pending.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
rtl/core/qrm_pkg.sv
rtl/core/qrm_front.sv
rtl/core/qrm_div_step.sv
rtl/core/qrm_round.sv
rtl/core/quaternion_to_rotation_matrix_top.sv
tb/testbench.sv
